// ----- design/olk_pkg.sv -----
// Shared types and codes for the ordered lock list.
`timescale 1ns / 1ps
`default_nettype none

package olk_pkg;

	// Fixed widths of the transaction fields
	localparam int RES_ID_W = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	// Operation codes
	localparam logic FUNC_ACQUIRE = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	// Update command broadcast to every cell
	typedef struct packed {
		logic append;
		logic remove;
	} olk_ctl_t;

	// Compare flags returned by each cell
	typedef struct packed {
		logic hit;
		logic gt;
	} olk_flags_t;

endpackage

`default_nettype wire

// ----- design/olk_cell.sv -----
// One slot of the lock list: holds an ID, compares it, loads a new ID or its neighbor's.
`timescale 1ns / 1ps
`default_nettype none

module olk_cell #(
	parameter int ID_WIDTH = 16,
	parameter int CNT_W    = 5,
	parameter int IDX      = 0
) (
	input  wire                      clk,
	input  wire [ID_WIDTH-1:0]       req_id,
	input  wire [CNT_W-1:0]          total,
	input  wire [ID_WIDTH-1:0]       nbr_id,
	input  olk_pkg::olk_ctl_t        ctl,
	output logic [ID_WIDTH-1:0]      id,
	output olk_pkg::olk_flags_t      flags
);

	logic [ID_WIDTH-1:0] id_q;
	logic                occ;
	logic                at_tail;

	// Slot holds a live entry when its position lies below the count
	assign occ     = CNT_W'(IDX) < total;
	assign at_tail = total == CNT_W'(IDX);

	// Compare the live entry against the request
	always_comb begin
		flags.hit = occ && (id_q == req_id);
		flags.gt  = occ && (id_q > req_id);
	end

	// Append at the tail, or pull the neighbor down when the gap is at or below us
	always_ff @(posedge clk) begin
		if (ctl.append && at_tail) begin
			id_q <= req_id;
		end else if (ctl.remove && occ && (id_q >= req_id)) begin
			id_q <= nbr_id;
		end
	end

	assign id = id_q;

endmodule

`default_nettype wire

// ----- design/ordered_lock_list_core.sv -----
// Top level of the ordered lock list: request register, row of cells and result register.
//
// Usage: raise start with func and resource_id; the transaction is taken at a rising edge
// where start is high and busy is low. func 0 acquires the ID (appended only if it is above
// the last held ID), func 1 releases it (the entry is removed and later entries move down).
// Only the low ID_WIDTH bits of resource_id are used.
// The result (status, held_count) appears with a one-cycle done strobe: the request is
// registered on acceptance, and the cell row and the result register are then updated
// together from that registered request.
// Throughput: one transaction per cycle while busy is low. Every cell compares its entry
// with the request in parallel and the whole row shifts in the same cycle, so the next request
// sees the updated list.
// Reset: arst_n clears the count and all control; busy stays high until the ready register
// is set after reset is released. Stored IDs are not cleared; only slots below the count are live.
// The receiver cannot stall: each result is valid only in its done cycle.
`timescale 1ns / 1ps
`default_nettype none

module ordered_lock_list_core #(
	parameter int MAX_LOCKS = 16,
	parameter int ID_WIDTH  = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire                              func,
	input  wire [olk_pkg::RES_ID_W-1:0]      resource_id,
	output logic                             done,
	output logic [olk_pkg::STATUS_W-1:0]     status,
	output logic [olk_pkg::COUNT_W-1:0]      held_count
);

	localparam int CNT_W = $clog2(MAX_LOCKS + 1);

	logic                         ready_q;
	logic                         accept;
	logic                         req_valid_s1;
	logic                         func_s1;
	logic [ID_WIDTH-1:0]          id_s1;
	logic [CNT_W-1:0]             total_q;
	logic [CNT_W-1:0]             total_d;
	logic [olk_pkg::STATUS_W-1:0] status_d;
	logic                         hit_any;
	logic                         gt_any;
	logic [MAX_LOCKS-1:0]         hit_vec;
	logic [MAX_LOCKS-1:0]         gt_vec;
	logic [ID_WIDTH-1:0]          cell_id [MAX_LOCKS];
	olk_pkg::olk_flags_t          cell_flags [MAX_LOCKS];
	olk_pkg::olk_ctl_t            ctl;
	logic                         done_q;
	logic [olk_pkg::STATUS_W-1:0] status_q;
	logic [olk_pkg::COUNT_W-1:0]  count_q;

	// Hold busy after reset release until this register is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy   = !ready_q;
	assign accept = start && ready_q;

	// Register the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else begin
			req_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			id_s1   <= ID_WIDTH'(resource_id);
		end
	end

	// Row of cells, each fed by its upper neighbor, the last by its own ID
	for (genvar i = 0; i < MAX_LOCKS; i++) begin : g_cell
		logic [ID_WIDTH-1:0] nbr;

		if (i == MAX_LOCKS - 1) begin : g_last
			assign nbr = cell_id[i];
		end else begin : g_mid
			assign nbr = cell_id[i+1];
		end

		olk_cell #(
			.ID_WIDTH (ID_WIDTH),
			.CNT_W    (CNT_W),
			.IDX      (i)
		) u_cell (
			.clk    (clk),
			.req_id (id_s1),
			.total  (total_q),
			.nbr_id (nbr),
			.ctl    (ctl),
			.id     (cell_id[i]),
			.flags  (cell_flags[i])
		);

		assign hit_vec[i] = cell_flags[i].hit;
		assign gt_vec[i]  = cell_flags[i].gt;
	end

	// The list is strictly rising, so the last entry is the largest
	assign hit_any = |hit_vec;
	assign gt_any  = |gt_vec;

	// Decide status and the row update
	always_comb begin
		ctl.append = 1'b0;
		ctl.remove = 1'b0;
		status_d   = olk_pkg::ST_OK;
		total_d    = total_q;
		if (func_s1 == olk_pkg::FUNC_ACQUIRE) begin
			priority if (gt_any) begin
				status_d = olk_pkg::ST_ORDER;
			end else if (hit_any) begin
				status_d = olk_pkg::ST_DUP;
			end else if (total_q == CNT_W'(MAX_LOCKS)) begin
				status_d = olk_pkg::ST_FULL;
			end else begin
				ctl.append = req_valid_s1;
				total_d    = total_q + 1'b1;
			end
		end else begin
			if (hit_any) begin
				ctl.remove = req_valid_s1;
				total_d    = total_q - 1'b1;
			end else begin
				status_d = olk_pkg::ST_NOTFOUND;
			end
		end
	end

	// Advance the count and raise the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= req_valid_s1;
			if (req_valid_s1) begin
				total_q <= total_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid_s1) begin
			status_q <= status_d;
			count_q  <= olk_pkg::COUNT_W'(total_d);
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign held_count = count_q;

	// Every result traces back to a registered request
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(req_valid_s1))
		else $error("result without request");

	// Count never exceeds the list depth
	a_total_max: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_LOCKS))
		else $error("lock count overflow");

	// Count moves only with a transaction in flight
	a_total_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!req_valid_s1 |=> $stable(total_q))
		else $error("lock count changed while idle");

	// A successful release drops the count by one
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid_s1 && func_s1 == olk_pkg::FUNC_RELEASE && hit_any)
		|=> total_q == $past(total_q) - 1'b1)
		else $error("release did not decrement count");

	// Append and remove never fire together
	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.append && ctl.remove))
		else $error("append and remove together");

endmodule

`default_nettype wire

// ----- bench/ordered_lock_list_core_test.sv -----
// Self-checking bench for the ordered lock list core: directed and random lock traffic.
`timescale 1ns / 1ps

module ordered_lock_list_core_test;

	localparam int LOCK_DEPTH   = 16;
	localparam int ID_BITS      = 16;
	localparam int RANDOM_ITEMS = 1025;
	localparam int QUIET_TAIL   = 150;

	typedef struct packed {
		logic [olk_pkg::STATUS_W-1:0] status;
		logic [olk_pkg::COUNT_W-1:0]  held_count;
	} lock_result_t;

	// Tracks the held list and the results still owed by the core
	class lock_list_scoreboard;
		logic [olk_pkg::RES_ID_W-1:0] held_ids[LOCK_DEPTH];
		int unsigned                  held_total;
		lock_result_t                 owed_q[$];
		int                           errors;
		int                           status_seen[5];
		int                           results_seen;
		int unsigned                  peak_held;

		function new();
			held_total   = 0;
			errors       = 0;
			results_seen = 0;
			peak_held    = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function logic [olk_pkg::RES_ID_W-1:0] last_id();
			return (held_total == 0) ? '0 : held_ids[held_total-1];
		endfunction

		// Apply one accepted transaction to the list and queue its result
		function void note_request(logic op, logic [olk_pkg::RES_ID_W-1:0] raw_id);
			logic [olk_pkg::RES_ID_W-1:0] id;
			logic [olk_pkg::STATUS_W-1:0] st;
			lock_result_t                 res;
			int                           slot;
			id   = raw_id & olk_pkg::RES_ID_W'((64'd1 << ID_BITS) - 1);
			slot = -1;
			if (op == olk_pkg::FUNC_ACQUIRE) begin
				if (held_total > 0 && id == held_ids[held_total-1])
					st = olk_pkg::ST_DUP;
				else if (held_total > 0 && id < held_ids[held_total-1])
					st = olk_pkg::ST_ORDER;
				else if (held_total >= LOCK_DEPTH)
					st = olk_pkg::ST_FULL;
				else begin
					held_ids[held_total] = id;
					held_total++;
					st = olk_pkg::ST_OK;
				end
			end else begin
				for (int j = 0; j < held_total; j++)
					if (slot < 0 && held_ids[j] == id) slot = j;
				if (slot < 0)
					st = olk_pkg::ST_NOTFOUND;
				else begin
					// close the gap by moving later entries down
					for (int k = slot; k + 1 < held_total; k++)
						held_ids[k] = held_ids[k+1];
					held_total--;
					st = olk_pkg::ST_OK;
				end
			end
			if (held_total > peak_held) peak_held = held_total;
			res.status     = st;
			res.held_count = olk_pkg::COUNT_W'(held_total);
			owed_q.push_back(res);
		endfunction

		// Compare one strobed result with the oldest owed one
		function void check_result(logic [olk_pkg::STATUS_W-1:0] st,
				logic [olk_pkg::COUNT_W-1:0] cnt);
			lock_result_t exp_res;
			if (owed_q.size() == 0) begin
				$error("unexpected result: status %0d held_count %0d", st, cnt);
				errors++;
				return;
			end
			exp_res = owed_q.pop_front();
			results_seen++;
			if (exp_res.status <= olk_pkg::ST_NOTFOUND) status_seen[exp_res.status]++;
			if (st !== exp_res.status) begin
				$error("status: expected %0d, actual %0d", exp_res.status, st);
				errors++;
			end
			if (cnt !== exp_res.held_count) begin
				$error("held_count: expected %0d, actual %0d", exp_res.held_count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         func;
	logic [olk_pkg::RES_ID_W-1:0] resource_id;
	logic                         done;
	logic [olk_pkg::STATUS_W-1:0] status;
	logic [olk_pkg::COUNT_W-1:0]  held_count;

	lock_list_scoreboard sb;

	ordered_lock_list_core #(
		.MAX_LOCKS (LOCK_DEPTH),
		.ID_WIDTH  (ID_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.resource_id (resource_id),
		.done        (done),
		.status      (status),
		.held_count  (held_count)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check results, then record the transaction taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) sb.check_result(status, held_count);
			if (start === 1'b1 && busy === 1'b0) sb.note_request(func, resource_id);
		end
	end

	// Hold one request until the core takes it
	task automatic send_request(input logic op, input logic [olk_pkg::RES_ID_W-1:0] id);
		start       <= 1'b1;
		func        <= op;
		resource_id <= id;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Drop start for a burst of cycles with random junk on the payload
	task automatic idle_sender(input int cycles);
		start       <= 1'b0;
		func        <= 1'($urandom);
		resource_id <= olk_pkg::RES_ID_W'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every owed result has come back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.owed_q.size() != 0) @(posedge clk);
	endtask

	// Pick the next random request; fill mode grows the list, drain mode empties it
	task automatic pick_request(input bit fill_mode, output logic op,
			output logic [olk_pkg::RES_ID_W-1:0] id);
		int unsigned                  roll;
		int unsigned                  cnt;
		int unsigned                  headroom;
		int unsigned                  gap;
		logic [olk_pkg::RES_ID_W-1:0] last;
		roll = $urandom_range(0, 99);
		cnt  = sb.held_total;
		last = sb.last_id();
		op   = olk_pkg::FUNC_ACQUIRE;
		id   = olk_pkg::RES_ID_W'($urandom);
		if (!fill_mode) begin
			if (roll < 80 && cnt > 0) begin
				op = olk_pkg::FUNC_RELEASE;
				id = sb.held_ids[$urandom_range(0, cnt - 1)];
			end else
				op = 1'($urandom);
		end else if (roll < 60) begin
			// in-order acquire, spaced so the list can reach full
			if (cnt == 0)
				id = olk_pkg::RES_ID_W'($urandom_range(0, 16'h3FFF));
			else begin
				headroom = 16'hFFFF - last;
				gap      = headroom / (LOCK_DEPTH - cnt + 1);
				id       = (gap == 0) ? olk_pkg::RES_ID_W'($urandom)
					: olk_pkg::RES_ID_W'(last + $urandom_range(1, gap));
			end
		end else if (roll < 72 && cnt > 0) begin
			op = olk_pkg::FUNC_RELEASE;
			id = sb.held_ids[$urandom_range(0, cnt - 1)];
		end else if (roll < 80) begin
			id = last;
		end else if (roll < 88) begin
			id = olk_pkg::RES_ID_W'($urandom_range(0, last));
		end else
			op = 1'($urandom);
	endtask

	initial begin : stimulus
		logic                         op;
		logic [olk_pkg::RES_ID_W-1:0] id;
		bit                           fill_mode;
		bit                           idle_on;
		int                           seq_left;

		sb          = new();
		arst_n      = 1'b0;
		start       = 1'b0;
		func        = olk_pkg::FUNC_ACQUIRE;
		resource_id = '0;
		fill_mode   = 1'b1;
		idle_on     = 1'b1;
		seq_left    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty release, duplicate, bad order, absent ID, full list
		send_request(olk_pkg::FUNC_RELEASE, 16'h0001);
		send_request(olk_pkg::FUNC_ACQUIRE, 16'h0000);
		send_request(olk_pkg::FUNC_ACQUIRE, 16'h0000);
		send_request(olk_pkg::FUNC_ACQUIRE, 16'h0007);
		send_request(olk_pkg::FUNC_ACQUIRE, 16'h0003);
		send_request(olk_pkg::FUNC_RELEASE, 16'h0009);
		send_request(olk_pkg::FUNC_RELEASE, 16'h0000);
		for (int k = 1; k <= 15; k++)
			send_request(olk_pkg::FUNC_ACQUIRE,
				(k == 15) ? 16'hFFFE : olk_pkg::RES_ID_W'(k * 16'h1000 + 7));
		send_request(olk_pkg::FUNC_ACQUIRE, 16'hFFFF);
		send_request(olk_pkg::FUNC_RELEASE, 16'h5007);
		send_request(olk_pkg::FUNC_RELEASE, 16'hFFFE);
		drain_results();

		// Random: fill and drain sequences in random order
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) drain_results();
			if (seq_left == 0) begin
				seq_left  = $urandom_range(8, 40);
				fill_mode = ($urandom_range(0, 99) < 55);
				idle_on   = ($urandom_range(0, 9) < 7);
			end
			seq_left--;
			if (idle_on && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 14));
			pick_request(fill_mode, op, id);
			send_request(op, id);
		end

		// Let the last results come back, then watch for strays
		drain_results();
		repeat (6) @(posedge clk);

		$display("Checked %0d lock transactions (peak %0d held): ok %0d, duplicate %0d,",
			sb.results_seen, sb.peak_held, sb.status_seen[olk_pkg::ST_OK],
			sb.status_seen[olk_pkg::ST_DUP]);
		$display("  poorly ordered %0d, list full %0d, not found %0d",
			sb.status_seen[olk_pkg::ST_ORDER], sb.status_seen[olk_pkg::ST_FULL],
			sb.status_seen[olk_pkg::ST_NOTFOUND]);
		if (sb.errors == 0 && sb.owed_q.size() == 0)
			$display("** ordered_lock_list_core: PASSED **");
		else
			$display("** ordered_lock_list_core: FAILED **");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("timeout waiting on the core");
		$display("** ordered_lock_list_core: FAILED **");
		$finish;
	end

endmodule
